// ===== src/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher.
// It has no dependencies. The controller, the datapath and the top level import it.
`default_nettype none

package rc4_pkg;

  localparam int SBOX_ENTRIES  = 256;
  localparam int SBOX_AW       = 8;
  localparam int BYTE_W        = 8;
  localparam int KEY_WORD_W    = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int MAX_KEY_BYTES = 16;
  localparam int KPOS_W        = 4;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  typedef enum logic [2:0] {
    RD_NEXT_I = 3'd0,
    RD_K      = 3'd1,
    RD_K_NEXT = 3'd2,
    RD_J      = 3'd3,
    RD_T      = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_FILL = 2'd0,
    WR_J_SI = 2'd1,
    WR_K_SJ = 2'd2,
    WR_I_SJ = 2'd3
  } wr_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    clr_sched;
    logic    inc_k;
    logic    load_j;
    logic    add_key;
    logic    cap_sj;
    logic    accept;
    logic    load_out;
    logic    hold_ks;
    logic    out_held;
    logic    reset_ij;
  } rc4_cmd_t;

  typedef struct packed {
    logic k_last;
    logic out_free;
  } rc4_sts_t;

endpackage

`default_nettype wire

// ===== src/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// It has no dependencies. Reading an address in the same cycle it is written returns the old data.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [WIDTH-1:0]          wr_data,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/rc4_ctrl.sv =====
// Controller for the RC4 stream cipher: key schedule and keystream sequencing.
// It depends on rc4_pkg and drives the datapath through rc4_cmd_t.
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  input  wire            in_tlast,
  output logic           in_tready,
  input  wire rc4_sts_t  sts,
  output rc4_cmd_t       cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_FILL = 10'b0000000010,
    ST_KA   = 10'b0000000100,
    ST_KB   = 10'b0000001000,
    ST_KC   = 10'b0000010000,
    ST_KD   = 10'b0000100000,
    ST_GB   = 10'b0001000000,
    ST_GC   = 10'b0010000000,
    ST_GW   = 10'b0100000000,
    ST_GH   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   need_sched_r, need_sched_nxt;
  logic   accept;

  assign in_tready = ((state_r == ST_IDLE) || (state_r == ST_GW) || (state_r == ST_GH))
                     && !need_sched_r && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    need_sched_nxt = need_sched_r;
    cmd            = '0;
    cmd.rd_sel     = RD_NEXT_I;
    cmd.wr_sel     = WR_FILL;
    cmd.accept     = accept;
    if (accept) begin
      need_sched_nxt = in_tlast;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (need_sched_r && in_tvalid) begin
          cmd.clr_sched = 1'b1;
          state_nxt     = ST_FILL;
        end else if (accept) begin
          state_nxt = ST_GB;
        end
      end
      ST_FILL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_FILL;
        cmd.inc_k  = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_KA;
        end
      end
      ST_KA: begin
        cmd.rd_sel = RD_K;
        state_nxt  = ST_KB;
      end
      ST_KB: begin
        cmd.load_j  = 1'b1;
        cmd.add_key = 1'b1;
        cmd.rd_sel  = RD_J;
        state_nxt   = ST_KC;
      end
      ST_KC: begin
        cmd.cap_sj = 1'b1;
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_J_SI;
        state_nxt  = ST_KD;
      end
      ST_KD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_K_SJ;
        cmd.rd_sel = RD_K_NEXT;
        cmd.inc_k  = 1'b1;
        if (sts.k_last) begin
          cmd.reset_ij   = 1'b1;
          need_sched_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_KB;
        end
      end
      ST_GB: begin
        cmd.load_j = 1'b1;
        cmd.rd_sel = RD_J;
        state_nxt  = ST_GC;
      end
      ST_GC: begin
        cmd.cap_sj = 1'b1;
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_J_SI;
        cmd.rd_sel = RD_T;
        state_nxt  = ST_GW;
      end
      ST_GW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_I_SJ;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = accept ? ST_GB : ST_IDLE;
        end else begin
          cmd.hold_ks = 1'b1;
          state_nxt   = ST_GH;
        end
      end
      ST_GH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_held = 1'b1;
          state_nxt    = accept ? ST_GB : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      need_sched_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      need_sched_r <= need_sched_nxt;
    end
  end

  a_last_arms_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> need_sched_r)
    else $error("last beat did not arm the key schedule");

  a_sched_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KD && sts.k_last) |=> (state_r == ST_IDLE && !need_sched_r))
    else $error("key schedule did not return to idle");

  a_gen_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GW) |-> ($past(state_r, 2) == ST_GB))
    else $error("keystream write-back out of sequence");

endmodule

`default_nettype wire

// ===== src/rc4_dp.sv =====
// Datapath for the RC4 stream cipher: key registers, indices, S-box RAM and output register.
// It depends on rc4_pkg and rc4_ram and is driven by the controller through rc4_cmd_t.
`default_nettype none

module rc4_dp
  import rc4_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [KEY_WORD_W-1:0]  cfg_wdata,
  input  wire [BYTE_W-1:0]      in_data,
  input  wire                   in_last,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [BYTE_W-1:0]     out_data,
  output logic                  out_last,
  input  wire rc4_cmd_t         cmd,
  output rc4_sts_t              sts
);

  logic [KEY_WORD_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [SBOX_AW-1:0]    k_r, i_r, j_r, j_nxt;
  logic [KPOS_W-1:0]     kpos_r, kpos_max;
  logic [BYTE_W-1:0]     si_r, sj_r, t_val, key_byte, ks_byte;
  logic [BYTE_W-1:0]     ks_r;
  logic [BYTE_W-1:0]     data_r;
  logic                  last_r;
  logic                  byp_j_r, byp_i_r;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic                  out_last_r;
  logic [2*KEY_WORD_W-1:0] key_all;
  logic                  ram_we;
  logic [SBOX_AW-1:0]    ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_WORD_LOW:  key_lo_r  <= cfg_wdata;
        REG_KEY_WORD_HIGH: key_hi_r  <= cfg_wdata;
        REG_KEY_LENGTH:    key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (key_len_r <= KEY_LEN_W'(1)) begin
      kpos_max = '0;
    end else if (key_len_r >= KEY_LEN_W'(MAX_KEY_BYTES)) begin
      kpos_max = KPOS_W'(MAX_KEY_BYTES - 1);
    end else begin
      kpos_max = KPOS_W'(key_len_r - KEY_LEN_W'(1));
    end
  end

  assign key_all  = {key_hi_r, key_lo_r};
  assign key_byte = key_all[{kpos_r, 3'b000} +: BYTE_W];
  assign j_nxt    = j_r + ram_rdata + (cmd.add_key ? key_byte : '0);
  assign t_val    = si_r + ram_rdata;
  assign ks_byte  = byp_j_r ? si_r : (byp_i_r ? sj_r : ram_rdata);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEXT_I: ram_raddr = i_r + SBOX_AW'(1);
      RD_K:      ram_raddr = k_r;
      RD_K_NEXT: ram_raddr = k_r + SBOX_AW'(1);
      RD_J:      ram_raddr = j_nxt;
      RD_T:      ram_raddr = t_val;
      default:   ram_raddr = i_r;
    endcase
  end

  always_comb begin
    ram_we = cmd.wr_en;
    unique case (cmd.wr_sel)
      WR_FILL: begin
        ram_waddr = k_r;
        ram_wdata = k_r;
      end
      WR_J_SI: begin
        ram_waddr = j_r;
        ram_wdata = si_r;
      end
      WR_K_SJ: begin
        ram_waddr = k_r;
        ram_wdata = sj_r;
      end
      WR_I_SJ: begin
        ram_waddr = i_r;
        ram_wdata = sj_r;
      end
      default: begin
        ram_waddr = k_r;
        ram_wdata = k_r;
      end
    endcase
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_ENTRIES)
  ) u_sbox (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      kpos_r <= '0;
      i_r    <= '0;
      j_r    <= '0;
    end else begin
      if (cmd.clr_sched) begin
        k_r    <= '0;
        kpos_r <= '0;
        j_r    <= '0;
      end else begin
        if (cmd.inc_k) begin
          k_r <= k_r + SBOX_AW'(1);
        end
        if (cmd.add_key && cmd.load_j) begin
          kpos_r <= (kpos_r == kpos_max) ? '0 : kpos_r + KPOS_W'(1);
        end
        if (cmd.reset_ij) begin
          i_r <= '0;
          j_r <= '0;
        end else begin
          if (cmd.accept) begin
            i_r <= i_r + SBOX_AW'(1);
          end
          if (cmd.load_j) begin
            j_r <= j_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_j) begin
      si_r <= ram_rdata;
    end
    if (cmd.cap_sj) begin
      sj_r    <= ram_rdata;
      byp_j_r <= (t_val == j_r);
      byp_i_r <= (t_val == i_r);
    end
    if (cmd.hold_ks) begin
      ks_r <= ks_byte;
    end
    if (cmd.accept) begin
      data_r <= in_data;
      last_r <= in_last;
    end
    if (cmd.load_out) begin
      out_data_r <= data_r ^ (cmd.out_held ? ks_r : ks_byte);
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_last     = out_last_r;
  assign sts.k_last   = (k_r == SBOX_AW'(SBOX_ENTRIES - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  a_out_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register loaded while a beat was pending");

endmodule

`default_nettype wire

// ===== src/rc4_stream_cipher.sv =====
// An accepted byte passes through states ST_GB, ST_GC and ST_GW; its result is then
// registered in the output register, and a full output stalls it in ST_GH. The next
// byte can be accepted in ST_GW or ST_GH; the S-box RAM's port sets the pace. Each
// message's first byte waits for the key schedule: a 256-entry fill, then keyed swaps.
// Synchronous active-low reset clears the key to zero, sets the key length to 16 and
// arms the key schedule; the S-box is not cleared and is filled by the schedule.
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [KEY_WORD_W-1:0]  cfg_wdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  wire                   in_tlast,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] result_byte
  output logic                  out_tlast
);

  rc4_cmd_t cmd;
  rc4_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
